// ===== rtl/searchable_fifo_queue_assert.svh =====
// assertion macros for the searchable fifo queue
// expects clk and rst_n in the scope of use
`ifndef SEARCHABLE_FIFO_QUEUE_ASSERT_SVH
`define SEARCHABLE_FIFO_QUEUE_ASSERT_SVH

// same-cycle implication
`define SFQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SFQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/sfq_pkg.sv =====
// shared types and constants for the searchable fifo queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam logic [4:0] CAPACITY_RESET = 5'd16;

    typedef enum logic [2:0] {
        OP_PUSH      = 3'd0,
        OP_POP       = 3'd1,
        OP_SEARCH    = 3'd2,
        OP_PEEK_OLD  = 3'd3,
        OP_PEEK_NEW  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef struct packed {
        logic        [2:0]  opcode;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] data;
        status_t            status;
        logic        [4:0]  occupancy;
    } out_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic compare;
        logic occupied;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sfq_cell.sv =====
// one storage cell of the queue chain: load, shift from neighbor, compare
// depends on sfq_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfq_cell #(
    parameter int WORD_BITS = sfq_pkg::WORD_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sfq_pkg::cell_ctrl_t  ctrl,
    input  wire logic [WORD_BITS-1:0] push_word,
    input  wire logic [WORD_BITS-1:0] next_word,
    input  wire logic [WORD_BITS-1:0] key,
    output logic      [WORD_BITS-1:0] word,
    output logic                      hit
);
    import sfq_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic                 hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            word_reg <= push_word;
        end
        else if (ctrl.shift)
        begin
            word_reg <= next_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.compare)
        begin
            hit_reg <= ctrl.occupied && (word_reg == key);
        end
    end

    assign word = word_reg;
    assign hit  = hit_reg;

endmodule

`default_nettype wire

// ===== rtl/searchable_fifo_queue.sv =====
// top level of the searchable fifo queue: control, count and result register
// depends on sfq_pkg, sfq_cell and searchable_fifo_queue_assert.svh
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel: drive cmd and raise start; the command is taken at a rising
//   edge with start high and busy low. busy is high in the cycle after
//   a command is taken.
//   Result channel: done rises at the edge after the command was taken and is
//   high for exactly one cycle, with result valid in that cycle; the result
//   is taken at the edge that ends done's cycle. The receiver cannot stall;
//   done marks a result in that cycle only; result holds till the next one.
//   No command is taken while busy is high. When one is, the cell chain
//   shifts or loads and, for a search, every cell registers its compare
//   against the key; then the cell hit bits are reduced and the result formed.
//   A new command may be taken in the cycle its predecessor's result shows.
//   Configuration: cfg_we writes cfg_wdata as capacity; write only when idle.
//   Reset: asynchronous, clears the entry count, capacity to 16 and control
//   flags; cell contents stay undefined and are never read unless written.
module searchable_fifo_queue #(
    parameter int DEPTH     = sfq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = sfq_pkg::WORD_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire sfq_pkg::in_t  cmd,
    output logic               done,
    output sfq_pkg::out_t      result,
    input  wire logic          cfg_we,
    input  wire logic [4:0]    cfg_wdata
);
    import sfq_pkg::*;

`include "searchable_fifo_queue_assert.svh"

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    logic [4:0]           capacity_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic                 busy_reg;
    logic                 done_reg;
    out_t                 result_reg, result_next;
    logic [WORD_BITS-1:0] newest_reg;
    logic [WORD_BITS-1:0] key_reg;
    logic                 search_reg;
    status_t              st_reg, st_next;
    logic signed [31:0]   data_reg, data_next;

    logic [WORD_BITS-1:0] key_w;
    logic [WORD_BITS-1:0] words [DEPTH];
    logic [DEPTH-1:0]     hits;
    logic                 accept, full, empty;
    logic                 is_push, is_pop, is_search, is_peek_old, is_peek_new;
    logic                 push_ok, pop_ok;

    assign key_w       = WORD_BITS'(cmd.value);
    assign accept      = start && !busy_reg;
    assign is_push     = cmd.opcode == OP_PUSH;
    assign is_pop      = cmd.opcode == OP_POP;
    assign is_search   = cmd.opcode == OP_SEARCH;
    assign is_peek_old = cmd.opcode == OP_PEEK_OLD;
    assign is_peek_new = cmd.opcode == OP_PEEK_NEW;
    assign empty       = count_reg == '0;
    assign full        = (LW'(count_reg) >= LW'(capacity_reg)) ||
                         (LW'(count_reg) >= LW'(DEPTH));
    assign push_ok     = accept && is_push && !full;
    assign pop_ok      = accept && is_pop && !empty;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cell_ctrl_t           ctrl;
            logic [WORD_BITS-1:0] nxt;

            assign ctrl.load     = push_ok && (count_reg == CW'(i));
            assign ctrl.shift    = pop_ok;
            assign ctrl.compare  = accept && is_search;
            assign ctrl.occupied = count_reg > CW'(i);

            if (i == DEPTH - 1)
            begin : g_last
                assign nxt = '0;
            end
            else
            begin : g_mid
                assign nxt = words[i+1];
            end

            sfq_cell #(
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .push_word (key_w),
                .next_word (nxt),
                .key       (key_w),
                .word      (words[i]),
                .hit       (hits[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // first phase: status and data that need no search
    always_comb
    begin
        st_next   = ST_OK;
        data_next = '0;
        if (is_push)
        begin
            if (full)
            begin
                st_next = ST_FULL;
            end
        end
        else if (is_pop || is_search || is_peek_old || is_peek_new)
        begin
            if (empty)
            begin
                st_next = ST_EMPTY;
            end
            else if (is_pop || is_peek_old)
            begin
                data_next = 32'($signed(words[0]));
            end
            else if (is_peek_new)
            begin
                data_next = 32'($signed(newest_reg));
            end
        end
    end

    // second phase: resolve search from registered cell hits
    always_comb
    begin
        result_next.data      = data_reg;
        result_next.status    = st_reg;
        result_next.occupancy = 5'(count_reg);
        if (search_reg)
        begin
            if (|hits)
            begin
                result_next.data = 32'($signed(key_reg));
            end
            else
            begin
                result_next.data   = '0;
                result_next.status = ST_MISS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            count_reg    <= '0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            search_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            busy_reg  <= accept;
            done_reg  <= busy_reg;
            if (accept)
            begin
                search_reg <= is_search && !empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg   <= st_next;
            data_reg <= data_next;
            key_reg  <= key_w;
        end
        if (push_ok)
        begin
            newest_reg <= key_w;
        end
        if (busy_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    `SFQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
    `SFQ_ASSERT_NEXT(a_busy_done, busy, done && !busy)
    `SFQ_ASSERT_NOW(a_count_bound, 1'b1, LW'(count_reg) <= LW'(DEPTH))
    `SFQ_ASSERT_NOW(a_fail_zero, done && result.status != ST_OK, result.data == '0)

endmodule

`default_nettype wire
